// ----- hdl/nrc_pkg.sv -----
// shared types, sizes and helpers for the nearest reference classifier
`default_nettype none
package nrc_pkg;

  // table geometry and element format
  localparam int MAX_REFS      = 16;
  localparam int MAX_DIMS      = 8;
  localparam int ELEMENT_WIDTH = 16;

  // fixed field widths of the channels
  localparam int NUM_FIELDS = 8;
  localparam int FIELD_W    = 16;
  localparam int SLOT_W     = 4;
  localparam int OUT_IDX_W  = 4;
  localparam int DIMS_W     = 4;
  localparam int REFS_W     = 5;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // derived widths
  localparam int IDX_W  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int DIFF_W = ELEMENT_WIDTH + 1;
  localparam int SQ_W   = 2 * ELEMENT_WIDTH;
  localparam int DIST_W = SQ_W + $clog2(MAX_DIMS);

  // operation codes
  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  // register indexes
  localparam logic REG_DIMS = 1'b0;
  localparam logic REG_REFS = 1'b1;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef elem_t [MAX_DIMS-1:0]            elem_vec_t;

  // running best carried down the chain
  typedef struct packed {
    logic [DIST_W-1:0] sum_sq;
    logic [IDX_W-1:0]  idx;
  } best_t;

  // take a field as an element: low bits, zero filled when the element is wider
  function automatic elem_t to_elem(logic [FIELD_W-1:0] raw);
    logic [FIELD_W+ELEMENT_WIDTH-1:0] wide;
    wide = {{ELEMENT_WIDTH{1'b0}}, raw};
    return elem_t'(wide[ELEMENT_WIDTH-1:0]);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/nrc_in_if.sv -----
// input channel: valid/ready with one load or classify beat
`default_nettype none
interface nrc_in_if;
  import nrc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [SLOT_W-1:0]          ref_slot;
  logic signed [FIELD_W-1:0]  element_0;
  logic signed [FIELD_W-1:0]  element_1;
  logic signed [FIELD_W-1:0]  element_2;
  logic signed [FIELD_W-1:0]  element_3;
  logic signed [FIELD_W-1:0]  element_4;
  logic signed [FIELD_W-1:0]  element_5;
  logic signed [FIELD_W-1:0]  element_6;
  logic signed [FIELD_W-1:0]  element_7;

  modport source (
    output valid, operation, ref_slot,
    output element_0, element_1, element_2, element_3,
    output element_4, element_5, element_6, element_7,
    input  ready
  );

  modport sink (
    input  valid, operation, ref_slot,
    input  element_0, element_1, element_2, element_3,
    input  element_4, element_5, element_6, element_7,
    output ready
  );
endinterface
`default_nettype wire

// ----- hdl/nrc_out_if.sv -----
// result channel: valid/ready with the nearest index
`default_nettype none
interface nrc_out_if;
  import nrc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] nearest_index;

  modport source (
    output valid, nearest_index,
    input  ready
  );

  modport sink (
    input  valid, nearest_index,
    output ready
  );
endinterface
`default_nettype wire

// ----- hdl/nrc_cell.sv -----
// one chain cell: holds a reference vector, scores the passing query
`default_nettype none
module nrc_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      wr_en,
  input  wire nrc_pkg::elem_vec_t        wr_vec,
  input  wire logic [nrc_pkg::IDX_W-1:0] cell_idx,
  input  wire logic                      active,
  input  wire logic [nrc_pkg::MAX_DIMS-1:0] dim_mask,
  input  wire nrc_pkg::elem_vec_t        q_in,
  input  wire logic                      qv_in,
  input  wire nrc_pkg::best_t            best_in,
  output nrc_pkg::elem_vec_t             q_out,
  output logic                           qv_out,
  output nrc_pkg::best_t                 best_out,
  output logic                           bv_out
);
  import nrc_pkg::*;

  elem_vec_t               ref_r;
  elem_vec_t               q_r;
  logic                    qv_r;
  logic [SQ_W-1:0]         sq_r [MAX_DIMS];
  logic [SQ_W-1:0]         sq_nxt [MAX_DIMS];
  logic [DIST_W-1:0]       sum;
  best_t                   best_r;
  best_t                   best_nxt;
  logic                    bv_r;

  // reference row, written by a load beat aimed at this cell
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ref_r <= wr_vec;
    end
  end

  // per-component squared difference against the incoming query
  always_comb begin
    logic signed [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]          mag;
    logic [ELEMENT_WIDTH-1:0]   mag_n;
    for (int d = 0; d < MAX_DIMS; d++) begin
      diff  = DIFF_W'($signed(q_in[d])) - DIFF_W'($signed(ref_r[d]));
      mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      mag_n = mag[ELEMENT_WIDTH-1:0];
      sq_nxt[d] = dim_mask[d] ? (SQ_W'(mag_n) * SQ_W'(mag_n)) : '0;
    end
  end

  // first stage: query and squares
  always_ff @(posedge clk) begin
    q_r <= q_in;
    for (int d = 0; d < MAX_DIMS; d++) begin
      sq_r[d] <= sq_nxt[d];
    end
  end

  // sum of squares for this reference
  always_comb begin
    sum = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      sum = sum + DIST_W'(sq_r[d]);
    end
  end

  // second stage: keep the strictly smaller distance, earlier cell wins ties
  always_comb begin
    best_nxt = best_in;
    if (active && (sum < best_in.sum_sq)) begin
      best_nxt.sum_sq = sum;
      best_nxt.idx    = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (qv_r) begin
      best_r <= best_nxt;
    end
  end

  // valid flags move with the query
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r <= 1'b0;
      bv_r <= 1'b0;
    end else begin
      qv_r <= qv_in;
      bv_r <= qv_r;
    end
  end

  assign q_out    = q_r;
  assign qv_out   = qv_r;
  assign best_out = best_r;
  assign bv_out   = bv_r;

endmodule
`default_nettype wire

// ----- hdl/nearest_reference_classifier_unit.sv -----
// top level: config registers, load decode, cell chain and result register
//
// A load beat writes one reference vector into the cell that its slot names
// and gives no result; ready stays high for loads whenever no classify is
// under way. A classify beat enters a chain of MAX_REFS cells, one cell per
// reference; the query steps one cell per cycle while each cell squares its
// component differences and then folds its distance into the running best.
// Each cell registers the query and its squares, then the running best;
// the last cell's best moves into the output register, or waits at the
// chain end while the output still holds a result that was not taken.
// The input stays closed until that move, so one classify is in the
// chain at a time. The table has no reset: classifying over an entry that
// was never loaded gives an undefined index. Registers sit at byte 0
// (dimension_in_use) and byte 4 (active_references).
`default_nettype none
module nearest_reference_classifier_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  nrc_in_if.sink                                in_if,
  nrc_out_if.source                             out_if,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [nrc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [nrc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [nrc_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);
  import nrc_pkg::*;

  logic [DIMS_W-1:0]        dims_r;
  logic [REFS_W-1:0]        refs_r;
  logic                     cfg_wr;
  logic                     cfg_sel;

  logic [FIELD_W-1:0]       raw_fields [NUM_FIELDS];
  elem_vec_t                in_vec;
  logic                     in_acc;
  logic                     load_acc;
  logic                     cls_acc;

  logic [MAX_DIMS-1:0]      dim_mask;
  logic [MAX_REFS-1:0]      act;
  logic [MAX_REFS-1:0]      wr_en;

  elem_vec_t                q_chain  [MAX_REFS+1];
  logic                     qv_chain [MAX_REFS+1];
  best_t                    b_chain  [MAX_REFS+1];
  logic                     bv_last  [MAX_REFS];

  logic                     busy_r, busy_nxt;
  logic                     pend_r, pend_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic                     res_avail;
  logic                     res_take;
  logic [IDX_W+OUT_IDX_W-1:0] idx_wide;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_W'(8);
      refs_r <= REFS_W'(16);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_DIMS: dims_r <= cfg_pwdata[DIMS_W-1:0];
        REG_REFS: refs_r <= cfg_pwdata[REFS_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_DIMS: cfg_prdata = CFG_DATA_W'(dims_r);
      REG_REFS: cfg_prdata = CFG_DATA_W'(refs_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // components in use and cells searched, out-of-range values clamped
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      dim_mask[d] = (d == 0) || (int'(dims_r) > d);
    end
    for (int i = 0; i < MAX_REFS; i++) begin
      act[i] = (i == 0) || (int'(refs_r) > i);
    end
  end

  // input beat unpacking
  assign raw_fields[0] = in_if.element_0;
  assign raw_fields[1] = in_if.element_1;
  assign raw_fields[2] = in_if.element_2;
  assign raw_fields[3] = in_if.element_3;
  assign raw_fields[4] = in_if.element_4;
  assign raw_fields[5] = in_if.element_5;
  assign raw_fields[6] = in_if.element_6;
  assign raw_fields[7] = in_if.element_7;

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      in_vec[d] = (d < NUM_FIELDS) ? to_elem(raw_fields[d]) : '0;
    end
  end

  assign in_if.ready = !busy_r;
  assign in_acc      = in_if.valid && !busy_r;
  assign load_acc    = in_acc && (op_t'(in_if.operation) == OP_LOAD);
  assign cls_acc     = in_acc && (op_t'(in_if.operation) == OP_CLASSIFY);

  // slot decode for loads; slots past the table are dropped
  always_comb begin
    for (int i = 0; i < MAX_REFS; i++) begin
      wr_en[i] = load_acc && (int'(in_if.ref_slot) == i);
    end
  end

  // chain head: query from the beat, best seeded above any real distance
  assign q_chain[0]        = in_vec;
  assign qv_chain[0]       = cls_acc;
  assign b_chain[0].sum_sq = '1;
  assign b_chain[0].idx    = '0;

  for (genvar i = 0; i < MAX_REFS; i++) begin : g_cell
    nrc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_en[i]),
      .wr_vec   (in_vec),
      .cell_idx (IDX_W'(i)),
      .active   (act[i]),
      .dim_mask (dim_mask),
      .q_in     (q_chain[i]),
      .qv_in    (qv_chain[i]),
      .best_in  (b_chain[i]),
      .q_out    (q_chain[i+1]),
      .qv_out   (qv_chain[i+1]),
      .best_out (b_chain[i+1]),
      .bv_out   (bv_last[i])
    );
  end

  // result hand-off: the last cell's best holds until moved to the output
  assign res_avail = bv_last[MAX_REFS-1] || pend_r;
  assign res_take  = res_avail && (!out_valid_r || out_if.ready);
  assign idx_wide  = (IDX_W+OUT_IDX_W)'(b_chain[MAX_REFS].idx);

  always_comb begin
    busy_nxt      = busy_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = idx_wide[OUT_IDX_W-1:0];
      pend_nxt      = 1'b0;
      busy_nxt      = 1'b0;
    end else if (bv_last[MAX_REFS-1]) begin
      pend_nxt = 1'b1;
    end
    if (cls_acc) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_idx_r <= out_idx_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.nearest_index = out_idx_r;

endmodule
`default_nettype wire

// ----- sim/tb_nearest_reference_classifier_unit.sv -----
// testbench for the nearest reference classifier: directed and random beats against a scoreboard
module tb_nearest_reference_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import nrc_pkg::*;

  localparam int SETTLE_CYCLES  = MAX_REFS + 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 250;
  localparam int PHASE_BEATS    = 78;
  localparam int REPORT_LIMIT   = 10;
  localparam int LOAD_PERCENT   = 30;

  localparam elem_t ELEM_MIN = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
  localparam elem_t ELEM_MAX = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};

  // one input beat as seen on the channel
  typedef struct {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    elem_vec_t         vec;
  } beat_t;

  // reference table copy, register copy and queue of expected nearest indexes
  class nearest_index_scoreboard;
    elem_vec_t            ref_table [MAX_REFS];
    logic [DIMS_W-1:0]    dims_reg;
    logic [REFS_W-1:0]    refs_reg;
    logic [OUT_IDX_W-1:0] expected_index_q [$];
    int                   errors;
    int                   loads_seen;
    int                   queries_seen;
    int                   results_checked;

    function new();
      dims_reg        = DIMS_W'(MAX_DIMS);
      refs_reg        = REFS_W'(MAX_REFS);
      errors          = 0;
      loads_seen      = 0;
      queries_seen    = 0;
      results_checked = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_DIMS) begin
        dims_reg = value[DIMS_W-1:0];
      end else begin
        refs_reg = value[REFS_W-1:0];
      end
    endfunction

    // exact sum of squared component differences
    function longint unsigned squared_distance(elem_vec_t a, elem_vec_t b, int dims);
      longint unsigned acc;
      longint          diff;
      acc = 0;
      for (int d = 0; d < dims; d++) begin
        diff = longint'($signed(a[d])) - longint'($signed(b[d]));
        acc += diff * diff;
      end
      return acc;
    endfunction

    // argmin over the active entries, strict compare keeps the lowest index on ties
    function logic [OUT_IDX_W-1:0] nearest_index_of(elem_vec_t query);
      int              dims;
      int              refs;
      int              best_idx;
      longint unsigned best;
      longint unsigned span;
      dims = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
      refs = (refs_reg == 0) ? 1 : (refs_reg > MAX_REFS) ? MAX_REFS : int'(refs_reg);
      best     = squared_distance(ref_table[0], query, dims);
      best_idx = 0;
      for (int r = 1; r < refs; r++) begin
        span = squared_distance(ref_table[r], query, dims);
        if (span < best) begin
          best     = span;
          best_idx = r;
        end
      end
      return OUT_IDX_W'(best_idx);
    endfunction

    function void note_beat(beat_t b);
      if (b.op == OP_LOAD) begin
        ref_table[b.slot] = b.vec;
        loads_seen++;
      end else begin
        expected_index_q = {expected_index_q, nearest_index_of(b.vec)};
        queries_seen++;
      end
    endfunction

    function void check_result(logic [OUT_IDX_W-1:0] got);
      logic [OUT_IDX_W-1:0] want;
      results_checked++;
      if (expected_index_q.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $display("ERROR: result nearest_index=%0d with no classify waiting", got);
        errors++;
        return;
      end
      want = expected_index_q.pop_front();
      if (got !== want) begin
        if (errors < REPORT_LIMIT)
          $display("ERROR: nearest_index expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_index_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  wire  [CFG_DATA_W-1:0] cfg_prdata;
  wire                   cfg_pready;

  nrc_in_if  in_ch ();
  nrc_out_if out_ch ();

  nearest_index_scoreboard sb;
  bit no_idle;
  bit hold_request;
  int idle_cycles;
  int settings_used;

  nearest_reference_classifier_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always #6 clk = ~clk;

  // beat monitor, result check and watchdog
  always @(posedge clk) begin
    beat_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.nearest_index);
      if (in_ch.valid && in_ch.ready) begin
        seen.op   = op_t'(in_ch.operation);
        seen.slot = in_ch.ref_slot;
        seen.vec  = {in_ch.element_7, in_ch.element_6, in_ch.element_5, in_ch.element_4,
                     in_ch.element_3, in_ch.element_2, in_ch.element_1, in_ch.element_0};
        sb.note_beat(seen);
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_nearest_reference_classifier_unit failed");
      $finish;
    end
  end

  // gap lengths: mostly none or short, now and then long
  function automatic int send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int recv_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // result receiver with random stalls and one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (recv_gap()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // element and vector generators
  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2, 3:    return elem_t'(int'($urandom_range(0, 64)) - 32);
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic elem_vec_t rand_vec();
    elem_vec_t v;
    for (int d = 0; d < MAX_DIMS; d++) v[d] = rand_elem();
    return v;
  endfunction

  // query a few steps off a stored reference, wrapping at the ends
  function automatic elem_vec_t near_vec(int r);
    elem_vec_t v;
    for (int d = 0; d < MAX_DIMS; d++)
      v[d] = sb.ref_table[r][d] + elem_t'(int'($urandom_range(0, 6)) - 3);
    return v;
  endfunction

  function automatic beat_t beat_of(op_t op, int slot, elem_vec_t vec);
    beat_t b;
    b.op   = op;
    b.slot = SLOT_W'(slot);
    b.vec  = vec;
    return b;
  endfunction

  // random beat: loads with fresh or duplicated vectors, queries exact, near or random
  function automatic beat_t make_beat(int load_pct);
    beat_t b;
    int    r;
    r      = $urandom_range(0, MAX_REFS - 1);
    b.slot = SLOT_W'($urandom);
    if ($urandom_range(0, 99) < load_pct) begin
      b.op  = OP_LOAD;
      b.vec = ($urandom_range(0, 4) == 0) ? sb.ref_table[r] : rand_vec();
    end else begin
      b.op = OP_CLASSIFY;
      case ($urandom_range(0, 4))
        0:       b.vec = sb.ref_table[r];
        1, 2:    b.vec = near_vec(r);
        default: b.vec = rand_vec();
      endcase
    end
    return b;
  endfunction

  // drive one beat and hold it until taken; valid stays high on return
  task automatic send_beat(beat_t b, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= b.op;
    in_ch.ref_slot  <= b.slot;
    in_ch.element_0 <= b.vec[0];
    in_ch.element_1 <= b.vec[1];
    in_ch.element_2 <= b.vec[2];
    in_ch.element_3 <= b.vec[3];
    in_ch.element_4 <= b.vec[4];
    in_ch.element_5 <= b.vec[5];
    in_ch.element_6 <= b.vec[6];
    in_ch.element_7 <= b.vec[7];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop sending, wait for every expected result, then let the block settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic cfg_write(logic idx, logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int dims, int refs);
    drain_results();
    cfg_write(REG_DIMS, CFG_DATA_W'(dims));
    cfg_write(REG_REFS, CFG_DATA_W'(refs));
    settings_used++;
  endtask

  // fill every slot with extremes, a duplicated pair and random vectors, then probe
  task automatic run_directed();
    elem_vec_t ramp;
    elem_vec_t alt;
    for (int d = 0; d < MAX_DIMS; d++) begin
      ramp[d] = elem_t'((d % 2) ? -(d + 1) : (d + 1));
      alt[d]  = (d % 2) ? ELEM_MIN : ELEM_MAX;
    end
    send_beat(beat_of(OP_LOAD, 0, {MAX_DIMS{ELEM_MIN}}), send_gap());
    send_beat(beat_of(OP_LOAD, 1, {MAX_DIMS{ELEM_MAX}}), send_gap());
    send_beat(beat_of(OP_LOAD, 2, '0), send_gap());
    send_beat(beat_of(OP_LOAD, 3, ramp), send_gap());
    send_beat(beat_of(OP_LOAD, 4, alt), send_gap());
    // same vector as slot 3 so an exact query ties
    send_beat(beat_of(OP_LOAD, 5, ramp), send_gap());
    for (int s = 6; s < MAX_REFS; s++) send_beat(beat_of(OP_LOAD, s, rand_vec()), send_gap());
    send_beat(beat_of(OP_CLASSIFY, 0, {MAX_DIMS{ELEM_MAX}}), send_gap());
    send_beat(beat_of(OP_CLASSIFY, 7, {MAX_DIMS{ELEM_MIN}}), send_gap());
    send_beat(beat_of(OP_CLASSIFY, 0, '0), send_gap());
    send_beat(beat_of(OP_CLASSIFY, 9, ramp), send_gap());
    send_beat(beat_of(OP_CLASSIFY, 0, alt), send_gap());
    send_beat(beat_of(OP_CLASSIFY, 15, '1), send_gap());
    send_beat(beat_of(OP_CLASSIFY, 15, rand_vec()), send_gap());
  endtask

  // main sequence
  initial begin
    sb            = new();
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    idle_cycles   = 0;
    settings_used = 1;
    rst_n           <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_LOAD;
    in_ch.ref_slot  <= '0;
    in_ch.element_0 <= '0;
    in_ch.element_1 <= '0;
    in_ch.element_2 <= '0;
    in_ch.element_3 <= '0;
    in_ch.element_4 <= '0;
    in_ch.element_5 <= '0;
    in_ch.element_6 <= '0;
    in_ch.element_7 <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // phase 0 runs on the reset settings, later ones cover extremes and out of range codes
    for (int p = 0; p < 9; p++) begin
      case (p)
        1: set_config(1, 1);
        2: set_config(MAX_DIMS, MAX_REFS);
        3: set_config(0, 0);
        4: set_config(15, 31);
        5: set_config(3, 5);
        6: set_config(MAX_DIMS + 1, MAX_REFS + 1);
        7: set_config($urandom_range(1, MAX_DIMS), $urandom_range(1, MAX_REFS));
        8: set_config(2, MAX_REFS);
        default: ;
      endcase
      no_idle = (p == 4);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // long receiver hold-off while beats keep coming back to back
        if (p == 2 && i == 20) hold_request = 1'b1;
        // sender pause until the result queue is empty
        if (p == 5 && i == 40) drain_results();
        send_beat(make_beat(LOAD_PERCENT), (p == 2 && i >= 20 && i < 34) ? 0 : send_gap());
      end
    end
    no_idle = 1'b0;

    drain_results();
    $display("covered %0d loads and %0d classifies, %0d results checked, %0d errors",
             sb.loads_seen, sb.queries_seen, sb.results_checked, sb.errors);
    $display("over %0d register settings incl. minimum, maximum and out-of-range codes",
             settings_used);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_nearest_reference_classifier_unit passed");
    end else begin
      $display("tb_nearest_reference_classifier_unit failed");
    end
    $finish;
  end

endmodule
